### src/base58_encoder_defines.svh
// assertion macros for the base58 encoder checker
// expects clk and rst in the scope where a macro is used
`ifndef BASE58_ENCODER_DEFINES_SVH
`define BASE58_ENCODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define B58_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define B58_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/b58_pkg.sv
// shared types, constants and the alphabet lookup for the base58 encoder
// no dependencies
package b58_pkg;

  localparam int unsigned DIGIT_DEPTH = 44;
  localparam int unsigned DIGIT_W     = 6;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CHAR_W      = 7;

  // divide by 58 as floor((v >> 1) * RECIP >> RECIP_SHIFT), exact for v < 2^14
  localparam int unsigned RECIP_SHIFT = 23;
  localparam int unsigned PROD_W      = 32;
  localparam logic [18:0] RECIP       = 19'd289263;
  localparam logic [13:0] RADIX       = 14'd58;

  localparam logic [CHAR_W-1:0] ONE_CHAR = 7'd49;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [BYTE_W-1:0]  carry_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FOLD,
    ST_ALIGN,
    ST_ONES,
    ST_DIGITS
  } state_t;

  // controller to digit ring
  typedef struct packed {
    logic load;
    logic fold;
    logic emit;
  } ring_cmd_t;

  // digit ring to controller
  typedef struct packed {
    digit_t top;
    logic   carry_nz;
    logic   quo_nz;
  } ring_stat_t;

  // controller to output register
  typedef struct packed {
    logic valid;
    logic ones;
    logic last;
    logic too_long;
  } out_cmd_t;

  // digit value to bitcoin alphabet character
  function automatic logic [CHAR_W-1:0] b58_char(input digit_t d);
    logic [CHAR_W-1:0] c;
    priority if (d < 6'd9)  c = 7'd49 + 7'(d);  // '1'..'9'
    else if (d < 6'd17)     c = 7'd56 + 7'(d);  // 'A'..'H'
    else if (d < 6'd22)     c = 7'd57 + 7'(d);  // 'J'..'N'
    else if (d < 6'd33)     c = 7'd58 + 7'(d);  // 'P'..'Z'
    else if (d < 6'd44)     c = 7'd64 + 7'(d);  // 'a'..'k'
    else if (d < 6'd58)     c = 7'd65 + 7'(d);  // 'm'..'z'
    else                    c = ONE_CHAR;
    return c;
  endfunction

endpackage

### src/b58_divmod.sv
// one base-58 fold step: (digit * 256 + carry) split into digit and carry
// depends on b58_pkg
module b58_divmod
  import b58_pkg::*;
(
  input  digit_t digit,
  input  carry_t carry_in,
  output digit_t rem,
  output carry_t quo
);

  logic [13:0]       value;
  logic [PROD_W-1:0] prod;
  logic [8:0]        quo_full;
  logic [13:0]       quo_x58;
  logic [13:0]       rem_full;

  // value shifted up one byte plus incoming carry
  assign value = {digit, 8'd0} + 14'(carry_in);

  // quotient by reciprocal multiply on value / 2
  assign prod     = PROD_W'(value[13:1]) * PROD_W'(RECIP);
  assign quo_full = prod[PROD_W-1:RECIP_SHIFT];

  // remainder by back-multiply and subtract
  assign quo_x58  = 14'(quo_full) * RADIX;
  assign rem_full = value - quo_x58;

  assign rem = rem_full[DIGIT_W-1:0];
  assign quo = quo_full[BYTE_W-1:0];

endmodule

### src/b58_digit_ring.sv
// base-58 digit store as a shift ring with the carry register
// depends on b58_pkg and b58_divmod
module b58_digit_ring
  import b58_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  ring_cmd_t  cmd,
  input  carry_t     byte_in,
  output ring_stat_t stat
);

  digit_t store [DIGIT_DEPTH];
  carry_t carry;
  digit_t rem;
  carry_t quo;

  b58_divmod u_divmod (
    .digit    (store[0]),
    .carry_in (carry),
    .rem      (rem),
    .quo      (quo)
  );

  // fold shifts the least significant digit out of slot 0 through the divider and puts
  // the remainder in at the top; emit shifts toward the top, refilling with zeros
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIGIT_DEPTH; i++) store[i] <= '0;
      carry <= '0;
    end else if (cmd.load) begin
      carry <= byte_in;
    end else if (cmd.fold) begin
      for (int i = 0; i < DIGIT_DEPTH - 1; i++) store[i] <= store[i+1];
      store[DIGIT_DEPTH-1] <= rem;
      carry <= quo;
    end else if (cmd.emit) begin
      for (int i = DIGIT_DEPTH - 1; i > 0; i--) store[i] <= store[i-1];
      store[0] <= '0;
    end
  end

  // status back to the controller
  assign stat.top      = store[DIGIT_DEPTH-1];
  assign stat.carry_nz = |carry;
  assign stat.quo_nz   = |quo;

endmodule

### src/b58_ctrl.sv
// sequencer for byte folding and character emission, with message counters
// depends on b58_pkg
module b58_ctrl
  import b58_pkg::*;
#(
  parameter int unsigned MAX_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  carry_t     data_byte,
  input  logic       is_last,
  output logic       busy,
  output ring_cmd_t  ring_cmd,
  input  ring_stat_t ring_stat,
  output out_cmd_t   emit
);

  localparam cnt_t       MAX_CNT   = cnt_t'(MAX_BYTES);
  localparam cnt_t       DEPTH_CNT = cnt_t'(DIGIT_DEPTH);
  localparam cnt_t       LAST_POS  = cnt_t'(DIGIT_DEPTH - 1);
  localparam logic [CNT_W:0] DEPTH_TOT = (CNT_W + 1)'(DIGIT_DEPTH);

  state_t state, state_next;
  cnt_t   cnt, pos, sent;
  cnt_t   digit_count, digit_count_next;
  cnt_t   lead_zeros, byte_count;
  logic   in_lead, overflow, last_flag;
  logic   accept, take_byte, capped;
  logic   [CNT_W:0] total;
  cnt_t   emit_total;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign take_byte = accept && (byte_count < MAX_CNT);

  // digit count grows when a nonzero carry reaches an unused slot,
  // and clears once the message is out
  always_comb begin
    digit_count_next = digit_count;
    if (state == ST_FOLD && pos >= digit_count && ring_stat.carry_nz) begin
      digit_count_next = pos + cnt_t'(1);
    end else if (state == ST_DIGITS && cnt == '0) begin
      digit_count_next = '0;
    end
  end

  // characters to emit, capped at the store depth
  assign total      = {1'b0, lead_zeros} + {1'b0, digit_count};
  assign capped     = total > DEPTH_TOT;
  assign emit_total = capped ? DEPTH_CNT : total[CNT_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take_byte) state_next = ST_FOLD;
        else if (accept && is_last) state_next = ST_ALIGN;
      end
      ST_FOLD: begin
        if (pos == LAST_POS) state_next = last_flag ? ST_ALIGN : ST_IDLE;
      end
      ST_ALIGN: begin
        if (cnt == '0) state_next = ST_ONES;
      end
      ST_ONES: begin
        if (cnt == '0) state_next = ST_DIGITS;
      end
      ST_DIGITS: begin
        if (cnt == '0) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ring commands and output item
  always_comb begin
    ring_cmd.load = take_byte;
    ring_cmd.fold = (state == ST_FOLD);
    ring_cmd.emit = (state == ST_ALIGN || state == ST_DIGITS) && (cnt != '0);
    emit.valid    = (state == ST_ONES || state == ST_DIGITS) && (cnt != '0)
                    && (sent < DEPTH_CNT);
    emit.ones     = (state == ST_ONES);
    emit.last     = (sent == emit_total - cnt_t'(1));
    emit.too_long = overflow || capped;
  end

  // state and message counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      pos         <= '0;
      sent        <= '0;
      digit_count <= '0;
      lead_zeros  <= '0;
      byte_count  <= '0;
      in_lead     <= 1'b1;
      overflow    <= 1'b0;
      last_flag   <= 1'b0;
    end else begin
      state       <= state_next;
      digit_count <= digit_count_next;
      unique case (state)
        ST_IDLE: begin
          if (take_byte) begin
            byte_count <= byte_count + cnt_t'(1);
            if (in_lead && data_byte == '0) lead_zeros <= lead_zeros + cnt_t'(1);
            else in_lead <= 1'b0;
            pos       <= '0;
            last_flag <= is_last;
          end else if (accept) begin
            // byte past the limit is dropped
            overflow <= 1'b1;
            cnt      <= DEPTH_CNT - digit_count;
            sent     <= '0;
          end
        end
        ST_FOLD: begin
          pos <= pos + cnt_t'(1);
          if (pos == LAST_POS) begin
            if (ring_stat.quo_nz) overflow <= 1'b1;
            cnt  <= DEPTH_CNT - digit_count_next;
            sent <= '0;
          end
        end
        ST_ALIGN: begin
          if (cnt == '0) cnt <= lead_zeros;
          else cnt <= cnt - cnt_t'(1);
        end
        ST_ONES: begin
          if (cnt == '0) cnt <= digit_count;
          else cnt <= cnt - cnt_t'(1);
          if (emit.valid) sent <= sent + cnt_t'(1);
        end
        ST_DIGITS: begin
          if (cnt == '0) begin
            // message done, back to empty
            lead_zeros  <= '0;
            byte_count  <= '0;
            in_lead     <= 1'b1;
            overflow    <= 1'b0;
            last_flag   <= 1'b0;
          end else begin
            cnt <= cnt - cnt_t'(1);
          end
          if (emit.valid) sent <= sent + cnt_t'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

### src/base58_encoder.sv
// Bytes: busy stays high while an accepted byte is folded, so no new byte is taken
// before the fold is done; the digit ring is walked once per byte through a single
// divide-by-58 unit. Last byte: the ring is shifted until its top holds the most
// significant digit (a last byte past the limit is dropped, not folded), then the
// '1's and the digits, one per cycle with a pause between runs. Output cannot stall.
// Synchronous reset clears the digit store and all counters.
// top level: base58 encoder with bitcoin alphabet
// depends on b58_pkg, b58_ctrl, b58_digit_ring
module base58_encoder
  import b58_pkg::*;
#(
  parameter int unsigned MAX_BYTES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              is_last,
  output logic              strobe,
  output logic [CHAR_W-1:0] char_code,
  output logic              final_char,
  output logic              too_long
);

  ring_cmd_t  ring_cmd;
  ring_stat_t ring_stat;
  out_cmd_t   emit;

  b58_ctrl #(
    .MAX_BYTES (MAX_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .data_byte (data_byte),
    .is_last   (is_last),
    .busy      (busy),
    .ring_cmd  (ring_cmd),
    .ring_stat (ring_stat),
    .emit      (emit)
  );

  b58_digit_ring u_ring (
    .clk     (clk),
    .rst     (rst),
    .cmd     (ring_cmd),
    .byte_in (data_byte),
    .stat    (ring_stat)
  );

  // output item register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe     <= 1'b0;
      final_char <= 1'b0;
    end else begin
      strobe     <= emit.valid;
      final_char <= emit.valid && emit.last;
    end
  end

  // character payload
  always_ff @(posedge clk) begin
    char_code <= emit.ones ? ONE_CHAR : b58_char(ring_stat.top);
    too_long  <= emit.too_long;
  end

endmodule

### src/b58_checker.sv
// port-level checks for the base58 encoder, bound to the top level
// depends on b58_pkg and base58_encoder_defines.svh
`include "base58_encoder_defines.svh"

module b58_checker
  import b58_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              strobe,
  input logic [CHAR_W-1:0] char_code,
  input logic              final_char
);

  // characters stay inside the alphabet range
  `B58_ASSERT_IMP(a_char_range, strobe, (char_code >= 7'd49) && (char_code <= 7'd122), "char out of range")

  // more characters follow, so the block is still busy
  `B58_ASSERT_IMP(a_busy_mid, strobe && !final_char, busy, "idle in the middle of an encoding")

  // an accepted item never sees a character in the next cycle
  `B58_ASSERT_NXT(a_no_char_after_take, start && !busy, !strobe, "char right after item taken")

  // two idle cycles in a row carry no character
  `B58_ASSERT_IMP(a_idle_quiet, !busy && $past(!busy), !strobe, "char while idle")

endmodule

bind base58_encoder b58_checker u_checker (.*);
